// File: hdl/fbr_pkg.sv
`timescale 1ns / 1ps
// Package of the framed packet receiver: codes, command and configuration
// types, sizing defaults and the BSD checksum step. No dependencies.
package fbr_pkg;

   localparam int MAX_PAYLOAD_DEF = 128;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int EVENT_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_BYTE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_BYTE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_SET_ID = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_GET_ID = 8'd3;

   localparam logic [BYTE_W-1:0] HEAD_BYTE_RST = 8'd204;
   localparam logic [BYTE_W-1:0] TAIL_BYTE_RST = 8'd185;
   localparam logic [BYTE_W-1:0] LED_SET_ID_RST = 8'd128;
   localparam logic [BYTE_W-1:0] LED_GET_ID_RST = 8'd129;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_LEN,
      PH_BODY,
      PH_CSUM,
      PH_EXPORT
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_LEN_OK,
      CMD_LEN_ERR,
      CMD_TAIL_ERR,
      CMD_CSUM_ERR,
      CMD_EXPORT,
      CMD_READ
   } cmd_op_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE       = 4'd0,
      EV_STORED     = 4'd1,
      EV_TAIL_ERR   = 4'd2,
      EV_CSUM_ERR   = 4'd3,
      EV_LEN_ERR    = 4'd4,
      EV_LED_SET    = 4'd5,
      EV_LED_REPORT = 4'd6,
      EV_BYTE_READ  = 4'd7,
      EV_NO_PACKET  = 4'd8
   } event_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [BYTE_W-1:0] idx;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] head_byte;
      logic [BYTE_W-1:0] tail_byte;
      logic [BYTE_W-1:0] led_set_id;
      logic [BYTE_W-1:0] led_get_id;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] bsd_add(input logic [BYTE_W-1:0] sum,
                                                 input logic [BYTE_W-1:0] b);
      bsd_add = {sum[0], sum[BYTE_W-1:1]} + b;
   endfunction

endpackage

// File: hdl/fbr_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the framed packet receiver: request, response and
// register write channels. Depends on fbr_pkg.
interface fbr_req_if;
   import fbr_pkg::*;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface fbr_rsp_if;
   import fbr_pkg::*;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;
   logic [BYTE_W-1:0]  pkt_id;
   logic [BYTE_W-1:0]  pkt_len;
   logic [BYTE_W-1:0]  data_out;
   logic               last;
   logic               available;
   logic [BYTE_W-1:0]  led_state;
   modport source (output valid, output event_res, output pkt_id, output pkt_len,
                   output data_out, output last, output available, output led_state,
                   input ready);
   modport sink (input valid, input event_res, input pkt_id, input pkt_len,
                 input data_out, input last, input available, input led_state,
                 output ready);
endinterface

interface fbr_csr_if;
   import fbr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/fbr_front.sv
`timescale 1ns / 1ps
// Front part: accepts request transactions, runs the line deframer and turns
// each request into one command for the queue. Depends on fbr_pkg, fbr_if.
module fbr_front #(
   parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   fbr_req_if.sink          req_ch,
   input  fbr_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             push,
   output fbr_pkg::cmd_type push_cmd
);
   import fbr_pkg::*;

   localparam int BUF_DEPTH = MAX_PAYLOAD + 1;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] exp_len_ff, exp_len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] csum_ff, csum_in;
   logic [BYTE_W-1:0] b;

   assign req_ch.ready = !q_full;
   assign push = req_ch.valid && !q_full;
   assign b = req_ch.rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         exp_len_ff <= '0;
         count_ff <= '0;
         csum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         exp_len_ff <= exp_len_in;
         count_ff <= count_in;
         csum_ff <= csum_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      exp_len_in = exp_len_ff;
      count_in = count_ff;
      csum_in = csum_ff;
      push_cmd.op = CMD_NONE;
      push_cmd.idx = count_ff;
      push_cmd.data = b;
      push_cmd.len = exp_len_ff - 8'd1;
      if (req_ch.req_type) begin
         push_cmd.op = CMD_READ;
      end else begin
         unique case (phase_ff)
            PH_HEAD: begin
               exp_len_in = '0;
               count_in = '0;
               csum_in = '0;
               if (b == cfg.head_byte) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               exp_len_in = b;
               if (b == '0 || {1'b0, b} > 9'(BUF_DEPTH)) begin
                  push_cmd.op = CMD_LEN_ERR;
                  phase_in = PH_HEAD;
               end else begin
                  push_cmd.op = CMD_LEN_OK;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (count_ff < exp_len_ff) begin
                  push_cmd.op = CMD_WRITE;
                  csum_in = bsd_add(csum_ff, b);
                  count_in = count_ff + 8'd1;
               end else if (b != cfg.tail_byte) begin
                  push_cmd.op = CMD_TAIL_ERR;
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               if (b != csum_ff) begin
                  push_cmd.op = CMD_CSUM_ERR;
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = PH_EXPORT;
               end
            end
            PH_EXPORT: begin
               push_cmd.op = CMD_EXPORT;
               phase_in = PH_HEAD;
            end
            default: begin
               phase_in = PH_HEAD;
            end
         endcase
      end
      if (!push) begin
         phase_in = phase_ff;
         exp_len_in = exp_len_ff;
         count_in = count_ff;
         csum_in = csum_ff;
      end
   end

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> count_ff <= exp_len_ff && exp_len_ff != '0
                              && {1'b0, exp_len_ff} <= 9'(BUF_DEPTH))
      else $error("deframer byte count out of range");

endmodule

// File: hdl/fbr_queue.sv
`timescale 1ns / 1ps
// Command queue between the front and back parts of the framed packet
// receiver. Depends on fbr_pkg.
module fbr_queue #(
   parameter int DEPTH = fbr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fbr_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             pop_valid,
   output fbr_pkg::cmd_type pop_cmd,
   input  logic             pop
);
   import fbr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full = count_ff == CW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !pop_valid))
      else $error("command queue overflow or underflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("command queue count exceeds depth");

endmodule

// File: hdl/fbr_back.sv
`timescale 1ns / 1ps
// Back part: executes queued commands against the two-bank payload memory,
// the stored packet state and the LED register, and holds the response
// register. Depends on fbr_pkg, fbr_if.
module fbr_back #(
   parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  fbr_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  fbr_pkg::cmd_type q_cmd,
   output logic             pop,
   fbr_rsp_if.source        rsp_ch
);
   import fbr_pkg::*;

   localparam int IDXW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int MEM_DEPTH = 2 * (2 ** IDXW);

   logic [BYTE_W-1:0] payload_mem [MEM_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              bank_ff, bank_in;
   logic              complete_ff, complete_in;
   logic [BYTE_W-1:0] stored_id_ff, stored_id_in;
   logic [BYTE_W-1:0] stored_len_ff, stored_len_in;
   logic [BYTE_W-1:0] read_idx_ff, read_idx_in;
   logic [BYTE_W-1:0] led_ff, led_in;
   logic [BYTE_W-1:0] asm_id_ff, asm_id_in;
   logic [BYTE_W-1:0] asm_first_ff, asm_first_in;

   logic              rsp_valid_ff, rsp_valid_in;
   event_type         rsp_event_ff, ev_c;
   logic [BYTE_W-1:0] rsp_id_ff, id_c;
   logic [BYTE_W-1:0] rsp_len_ff, len_c;
   logic [BYTE_W-1:0] rsp_data_ff, data_c;
   logic              rsp_last_ff, last_c;
   logic              rsp_rd_sel_ff, rd_sel_c;
   logic              rsp_avail_ff;
   logic [BYTE_W-1:0] rsp_led_ff;

   logic              wr_en;
   logic [IDXW:0]     wr_addr;
   logic [IDXW:0]     rd_addr;
   logic [BYTE_W-1:0] idx_next;

   assign pop = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rd_addr = {bank_ff, read_idx_ff[IDXW-1:0]};
   assign wr_addr = {!bank_ff, IDXW'(q_cmd.idx - 8'd1)};

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.event_res = rsp_event_ff;
   assign rsp_ch.pkt_id = rsp_id_ff;
   assign rsp_ch.pkt_len = rsp_len_ff;
   assign rsp_ch.data_out = rsp_rd_sel_ff ? rd_data_ff : rsp_data_ff;
   assign rsp_ch.last = rsp_last_ff;
   assign rsp_ch.available = rsp_avail_ff;
   assign rsp_ch.led_state = rsp_led_ff;

   always_comb begin
      bank_in = bank_ff;
      complete_in = complete_ff;
      stored_id_in = stored_id_ff;
      stored_len_in = stored_len_ff;
      read_idx_in = read_idx_ff;
      led_in = led_ff;
      asm_id_in = asm_id_ff;
      asm_first_in = asm_first_ff;
      ev_c = EV_NONE;
      id_c = '0;
      len_c = '0;
      data_c = '0;
      last_c = 1'b0;
      rd_sel_c = 1'b0;
      wr_en = 1'b0;
      idx_next = read_idx_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         unique case (q_cmd.op)
            CMD_NONE: begin
               ev_c = EV_NONE;
            end
            CMD_WRITE: begin
               if (q_cmd.idx == '0) begin
                  asm_id_in = q_cmd.data;
               end else begin
                  wr_en = 1'b1;
               end
               if (q_cmd.idx == 8'd1) begin
                  asm_first_in = q_cmd.data;
               end
            end
            CMD_LEN_OK: begin
               complete_in = 1'b0;
            end
            CMD_LEN_ERR: begin
               complete_in = 1'b0;
               ev_c = EV_LEN_ERR;
            end
            CMD_TAIL_ERR: begin
               ev_c = EV_TAIL_ERR;
            end
            CMD_CSUM_ERR: begin
               ev_c = EV_CSUM_ERR;
            end
            CMD_EXPORT: begin
               id_c = asm_id_ff;
               len_c = q_cmd.len;
               if (asm_id_ff == cfg.led_set_id) begin
                  if (q_cmd.len != '0) begin
                     led_in = asm_first_ff;
                  end
                  ev_c = EV_LED_SET;
                  data_c = led_in;
               end else if (asm_id_ff == cfg.led_get_id) begin
                  ev_c = EV_LED_REPORT;
                  data_c = led_ff;
               end else begin
                  ev_c = EV_STORED;
                  stored_len_in = q_cmd.len;
                  stored_id_in = asm_id_ff;
                  read_idx_in = '0;
                  complete_in = 1'b1;
                  bank_in = !bank_ff;
               end
            end
            CMD_READ: begin
               if (!complete_ff) begin
                  ev_c = EV_NO_PACKET;
               end else begin
                  ev_c = EV_BYTE_READ;
                  id_c = stored_id_ff;
                  len_c = stored_len_ff;
                  if (read_idx_ff < stored_len_ff) begin
                     rd_sel_c = 1'b1;
                     idx_next = read_idx_ff + 8'd1;
                  end
                  if (idx_next >= stored_len_ff) begin
                     last_c = 1'b1;
                     complete_in = 1'b0;
                     stored_len_in = '0;
                     stored_id_in = '0;
                     read_idx_in = '0;
                  end else begin
                     read_idx_in = idx_next;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         complete_ff <= 1'b0;
         stored_id_ff <= '0;
         stored_len_ff <= '0;
         read_idx_ff <= '0;
         led_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff <= bank_in;
         complete_ff <= complete_in;
         stored_id_ff <= stored_id_in;
         stored_len_ff <= stored_len_in;
         read_idx_ff <= read_idx_in;
         led_ff <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_id_ff <= asm_id_in;
      asm_first_ff <= asm_first_in;
      if (pop) begin
         rsp_event_ff <= ev_c;
         rsp_id_ff <= id_c;
         rsp_len_ff <= len_c;
         rsp_data_ff <= data_c;
         rsp_last_ff <= last_c;
         rsp_rd_sel_ff <= rd_sel_c;
         rsp_avail_ff <= complete_in;
         rsp_led_ff <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[wr_addr] <= q_cmd.data;
      end
      if (pop) begin
         rd_data_ff <= payload_mem[rd_addr];
      end
   end

   a_stored_len: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> stored_len_ff <= 8'(MAX_PAYLOAD))
      else $error("stored packet longer than payload buffer");

   a_read_idx: assert property (@(posedge clock) disable iff (reset)
      complete_ff && stored_len_ff != '0 |-> read_idx_ff < stored_len_ff)
      else $error("read index past end of stored packet");

   a_len_discard: assert property (@(posedge clock) disable iff (reset)
      pop && (q_cmd.op == CMD_LEN_OK || q_cmd.op == CMD_LEN_ERR) |=> !complete_ff)
      else $error("length byte did not discard stored packet");

endmodule

// File: hdl/framed_packet_receiver.sv
`timescale 1ns / 1ps
// Framed packet receiver: takes one request transaction per clock unless the
// command queue is full, either a line byte for the deframer or a read of the
// next stored payload byte, and returns exactly one response transaction for
// each, in order. A request becomes a command when accepted and is queued,
// then executed against the packet store; requests are accepted every cycle
// while responses are taken, and a command queue of QUEUE_DEPTH (default four)
// entries absorbs response back-pressure before the request side stalls.
// Payloads live in a two-bank memory of MAX_PAYLOAD bytes per bank, rounded
// up to a power of two: a frame is assembled in one bank and storing a packet
// swaps banks, so no copy cycles are needed and no clearing pass follows
// reset. Registers 0 to 3 are head byte, tail byte, LED set ID and LED get
// ID; they are to be written only while the block is idle, which it does not
// enforce. Depends on fbr_pkg, fbr_if, fbr_front, fbr_queue and fbr_back.
module framed_packet_receiver #(
   parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEF,
   parameter int QUEUE_DEPTH = fbr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fbr_req_if.sink    req_ch,
   fbr_rsp_if.source  rsp_ch,
   fbr_csr_if.sink    csr_ch
);
   import fbr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_valid;
   cmd_type q_cmd;
   logic    pop;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_HEAD_BYTE:  cfg_in.head_byte = csr_ch.data;
            CSR_TAIL_BYTE:  cfg_in.tail_byte = csr_ch.data;
            CSR_LED_SET_ID: cfg_in.led_set_id = csr_ch.data;
            CSR_LED_GET_ID: cfg_in.led_get_id = csr_ch.data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte <= HEAD_BYTE_RST;
         cfg_ff.tail_byte <= TAIL_BYTE_RST;
         cfg_ff.led_set_id <= LED_SET_ID_RST;
         cfg_ff.led_get_id <= LED_GET_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbr_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   fbr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd),
      .pop       (pop)
   );

   fbr_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
